// ===== src/ipac_pkg.sv =====
// ipac_pkg: word types, reservation codes and address type codes for the
// IP address classifier. No dependencies.
`default_nettype none

package ipac_pkg;

    typedef struct packed {
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] port;
    } ipac_item_t;

    typedef struct packed {
        logic [3:0] reservation;
        logic       reserved;
        logic       loopback;
        logic       multicast;
        logic       valid_res;
        logic       routable;
        logic [1:0] addr_type;
        logic       endpoint_valid;
        logic       endpoint_routable;
    } ipac_result_t;

    localparam logic [3:0] RES_NONE = 4'd0;
    localparam logic [3:0] RES_1918 = 4'd1;
    localparam logic [3:0] RES_2544 = 4'd2;
    localparam logic [3:0] RES_6598 = 4'd3;
    localparam logic [3:0] RES_5737 = 4'd4;
    localparam logic [3:0] RES_3927 = 4'd5;
    localparam logic [3:0] RES_3849 = 4'd6;
    localparam logic [3:0] RES_3964 = 4'd7;
    localparam logic [3:0] RES_4193 = 4'd8;
    localparam logic [3:0] RES_4380 = 4'd9;
    localparam logic [3:0] RES_4843 = 4'd10;
    localparam logic [3:0] RES_4862 = 4'd11;
    localparam logic [3:0] RES_6052 = 4'd12;
    localparam logic [3:0] RES_6145 = 4'd13;

    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_IPV4 = 2'd1;
    localparam logic [1:0] TYPE_IPV6 = 2'd2;

endpackage

`default_nettype wire

// ===== src/ip_address_classifier.sv =====
// ip_address_classifier: top level, input register, prefix match logic and
// result register. Depends on ipac_pkg.
//
// Usage:
//   Drive item with an IPv4 or IPv6 address and a port and raise start for
//   one cycle per word. busy stays low, so a word is taken on every edge at
//   which start is high; a new word may follow in every cycle.
//   Each word gives exactly one result word on result, marked by done for
//   one cycle. The receiver cannot stall, so the result must be taken in
//   that cycle.
//   The path from the accepting edge to the done cycle runs through the
//   input register, then the result register.
//   Throughput: one word per cycle, set by the single pass of prefix
//   compares between the two registers.
//   Reset (rst_n low) clears both valid flags; no result is shown until a
//   word has been accepted after reset.
`default_nettype none

module ip_address_classifier
    import ipac_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire ipac_item_t   item,
    output logic              done,
    output ipac_result_t      result
);

    logic         valid_reg;
    ipac_item_t   item_reg;
    logic         done_reg;
    ipac_result_t result_reg;
    ipac_result_t result_next;

    logic [31:0] a4;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [31:0] w0;
    logic [3:0]  res_v4;
    logic [3:0]  res_v6;
    logic        zero;
    logic        loop;
    logic        mcast;
    logic [3:0]  res;
    logic        blocked;
    logic        rout;
    logic        port_ok;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign a4 = item_reg.addr_lo[31:0];
    assign b0 = a4[31:24];
    assign b1 = a4[23:16];
    assign b2 = a4[15:8];
    assign w0 = item_reg.addr_hi[63:32];

    always_comb
    begin
        res_v4 = RES_NONE;
        if (b0 == 8'd10 || (b0 == 8'd172 && b1[7:4] == 4'h1) ||
            (b0 == 8'd192 && b1 == 8'd168))
        begin
            res_v4 = RES_1918;
        end
        if (b0 == 8'd198 && b1[7:1] == 7'd9)
        begin
            res_v4 = RES_2544;
        end
        if (b0 == 8'h64 && b1[7:6] == 2'b01)
        begin
            res_v4 = RES_6598;
        end
        if ((b0 == 8'd192 && b1 == 8'd0 && b2 == 8'd2) ||
            (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'h64) ||
            (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113))
        begin
            res_v4 = RES_5737;
        end
        if (b0 == 8'd169 && b1 == 8'd254)
        begin
            res_v4 = RES_3927;
        end
    end

    always_comb
    begin
        res_v6 = RES_NONE;
        if (w0 == 32'h2001_0DB8)
        begin
            res_v6 = RES_3849;
        end
        if (w0[31:16] == 16'h2002)
        begin
            res_v6 = RES_3964;
        end
        if (w0[31:25] == 7'h7E)
        begin
            res_v6 = RES_4193;
        end
        if (w0 == 32'h2001_0000)
        begin
            res_v6 = RES_4380;
        end
        if (w0[31:4] == 28'h2001_001)
        begin
            res_v6 = RES_4843;
        end
        if (w0[31:16] == 16'hFE80)
        begin
            res_v6 = RES_4862;
        end
        if (w0 == 32'h0064_FF9B)
        begin
            res_v6 = RES_6052;
        end
        if (item_reg.addr_hi == 64'd0 && item_reg.addr_lo[63:32] == 32'hFFFF_0000)
        begin
            res_v6 = RES_6145;
        end
    end

    always_comb
    begin
        if (item_reg.is_v6)
        begin
            zero  = (item_reg.addr_hi == 64'd0) && (item_reg.addr_lo == 64'd0);
            loop  = (item_reg.addr_hi == 64'd0) && (item_reg.addr_lo == 64'd1);
            mcast = (item_reg.addr_hi[63:56] == 8'hFF);
            res   = zero ? RES_NONE : res_v6;
        end
        else
        begin
            zero  = (a4 == 32'd0);
            loop  = (b0 == 8'd127);
            mcast = (a4[31:28] == 4'hE);
            res   = zero ? RES_NONE : res_v4;
        end
    end

    always_comb
    begin
        case (res)
            RES_1918, RES_2544, RES_3927, RES_4862, RES_6598,
            RES_5737, RES_4193, RES_4843, RES_3849: blocked = 1'b1;
            default:                                blocked = 1'b0;
        endcase
    end

    assign rout    = !zero && !loop && !blocked;
    assign port_ok = (item_reg.port > 16'd1) && (item_reg.port != 16'hFFFF);

    always_comb
    begin
        result_next.reservation       = res;
        result_next.reserved          = (res != RES_NONE);
        result_next.loopback          = loop;
        result_next.multicast         = mcast;
        result_next.valid_res         = !zero;
        result_next.routable          = rout;
        result_next.addr_type         = !rout ? TYPE_NONE :
                                        (item_reg.is_v6 ? TYPE_IPV6 : TYPE_IPV4);
        result_next.endpoint_valid    = !zero && port_ok;
        result_next.endpoint_routable = rout && port_ok;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> done)
        else $error("accepted word did not produce a result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg))
        else $error("result shown without an accepted word");

    a_routable_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.routable |-> result.valid_res && !result.loopback)
        else $error("routable result for invalid or loopback address");

    a_type_needs_routable: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.addr_type != TYPE_NONE |-> result.routable)
        else $error("address type set on unroutable address");

    a_endpoint_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.endpoint_routable |-> result.endpoint_valid)
        else $error("endpoint routable without endpoint valid");

endmodule

`default_nettype wire

// ===== sim/tb_ip_address_classifier.sv =====
// tb_ip_address_classifier: self-checking testbench for the IP address classifier.
// It sends directed and prefix-biased random address words and checks every result
// word against a built-in classifier. Depends on ipac_pkg and ip_address_classifier.
`timescale 1ns / 100ps

module tb_ip_address_classifier
    import ipac_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned PHASE_WORDS = 370;

    class class_scoreboard;
        ipac_result_t class_q[$];
        int unsigned  fails;

        function ipac_result_t classify_address(ipac_item_t w);
            ipac_result_t r;
            logic [31:0]  a4;
            logic [31:0]  w0;
            logic [7:0]   b0;
            logic [7:0]   b1;
            logic [7:0]   b2;
            logic         zero;
            logic         loop;
            logic         port_ok;
            logic [3:0]   code;
            code = RES_NONE;
            a4 = w.addr_lo[31:0];
            w0 = w.addr_hi[63:32];
            b0 = a4[31:24];
            b1 = a4[23:16];
            b2 = a4[15:8];
            if (w.is_v6)
            begin
                zero = (w.addr_hi == '0) && (w.addr_lo == '0);
                loop = (w.addr_hi == '0) && (w.addr_lo == 64'd1);
                r.multicast = (w.addr_hi[63:56] == 8'hFF);
                if (!zero)
                begin
                    if (w0 == 32'h20010DB8) code = RES_3849;
                    if (w0[31:16] == 16'h2002) code = RES_3964;
                    if (w0[31:25] == 7'h7E) code = RES_4193;
                    if (w0 == 32'h20010000) code = RES_4380;
                    if (w0[31:4] == 28'h2001001) code = RES_4843;
                    if (w0[31:16] == 16'hFE80) code = RES_4862;
                    if (w0 == 32'h0064FF9B) code = RES_6052;
                    if (w.addr_hi == '0 && w.addr_lo[63:32] == 32'hFFFF0000) code = RES_6145;
                end
            end
            else
            begin
                zero = (a4 == '0);
                loop = (b0 == 8'd127);
                r.multicast = (a4[31:28] == 4'hE);
                if (!zero)
                begin
                    if (b0 == 8'd10 || (b0 == 8'd172 && b1 >= 8'd16 && b1 <= 8'd31) ||
                        (b0 == 8'd192 && b1 == 8'd168))
                        code = RES_1918;
                    if (b0 == 8'd198 && (b1 == 8'd18 || b1 == 8'd19)) code = RES_2544;
                    if (b0 == 8'd100 && b1 >= 8'd64 && b1 <= 8'd127) code = RES_6598;
                    if ((b0 == 8'd192 && b1 == 8'd0 && b2 == 8'd2) ||
                        (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'd100) ||
                        (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113))
                        code = RES_5737;
                    if (b0 == 8'd169 && b1 == 8'd254) code = RES_3927;
                end
            end
            r.reservation = code;
            r.reserved = (code != RES_NONE);
            r.loopback = loop;
            r.valid_res = !zero;
            r.routable = !zero && !loop;
            case (code)
                RES_1918, RES_2544, RES_3927, RES_4862, RES_6598,
                RES_5737, RES_4193, RES_4843, RES_3849: r.routable = 1'b0;
                default: ;
            endcase
            r.addr_type = !r.routable ? TYPE_NONE : (w.is_v6 ? TYPE_IPV6 : TYPE_IPV4);
            port_ok = (w.port > 16'd1) && (w.port < 16'hFFFF);
            r.endpoint_valid = !zero && port_ok;
            r.endpoint_routable = r.routable && port_ok;
            return r;
        endfunction

        function void note_address(ipac_item_t w);
            class_q.push_back(classify_address(w));
        endfunction

        function void check_field(string name, logic [3:0] e, logic [3:0] a);
            if (e !== a)
            begin
                fails++;
                if (fails <= 10)
                    $display("mismatch %s: expected %0h actual %0h", name, e, a);
            end
        endfunction

        function void check_class(ipac_result_t r);
            ipac_result_t e;
            if (class_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result word %h", r);
                return;
            end
            e = class_q.pop_front();
            check_field("reservation", e.reservation, r.reservation);
            check_field("reserved", 4'(e.reserved), 4'(r.reserved));
            check_field("loopback", 4'(e.loopback), 4'(r.loopback));
            check_field("multicast", 4'(e.multicast), 4'(r.multicast));
            check_field("valid_res", 4'(e.valid_res), 4'(r.valid_res));
            check_field("routable", 4'(e.routable), 4'(r.routable));
            check_field("addr_type", 4'(e.addr_type), 4'(r.addr_type));
            check_field("endpoint_valid", 4'(e.endpoint_valid), 4'(r.endpoint_valid));
            check_field("endpoint_routable", 4'(e.endpoint_routable),
                        4'(r.endpoint_routable));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    ipac_item_t   item;
    logic         done;
    ipac_result_t result;

    class_scoreboard sb = new();
    int unsigned     cycles = 0;

    ip_address_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (done)
            sb.check_class(result);
        if (start && !busy)
            sb.note_address(item);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic ipac_item_t make_word(logic v6, logic [63:0] hi, logic [63:0] lo,
                                             logic [15:0] p);
        ipac_item_t w;
        w.is_v6 = v6;
        w.addr_hi = hi;
        w.addr_lo = lo;
        w.port = p;
        return w;
    endfunction

    function automatic ipac_item_t random_address();
        ipac_item_t  w;
        logic [31:0] a;
        w.is_v6 = 1'($urandom_range(0, 1));
        w.addr_hi = {$urandom, $urandom};
        w.addr_lo = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w.port = 16'd0;
            1: w.port = 16'd1;
            2: w.port = 16'd2;
            3: w.port = 16'hFFFE;
            4: w.port = 16'hFFFF;
            default: w.port = 16'($urandom_range(0, 65535));
        endcase
        if (w.is_v6)
        begin
            case ($urandom_range(0, 15))
                0: w.addr_hi[63:32] = 32'h20010DB8;
                1: w.addr_hi[63:48] = 16'h2002;
                2: w.addr_hi[63:57] = 7'h7E;
                3: w.addr_hi[63:32] = 32'h20010000;
                4: w.addr_hi[63:36] = 28'h2001001;
                5: w.addr_hi[63:48] = 16'hFE80;
                6: w.addr_hi[63:32] = 32'h0064FF9B;
                7:
                begin
                    w.addr_hi = '0;
                    w.addr_lo[63:32] = 32'hFFFF0000;
                end
                8:
                begin
                    w.addr_hi = '0;
                    w.addr_lo = 64'($urandom_range(0, 3));
                end
                9: w.addr_hi[63:56] = 8'hFF;
                10:
                begin
                    w.addr_hi = '0;
                    w.addr_lo[63:32] = 32'hFFFF0000 ^ (32'd1 << $urandom_range(0, 31));
                end
                11:
                begin
                    w.addr_hi = '0;
                    w.addr_lo = '0;
                end
                12: w.addr_hi[63:32] = 32'h20010DB8 ^ (32'd1 << $urandom_range(0, 31));
                default: ;
            endcase
        end
        else
        begin
            a = $urandom;
            case ($urandom_range(0, 15))
                0: a[31:24] = 8'd10;
                1: a[31:16] = {8'd172, 8'($urandom_range(14, 33))};
                2: a[31:16] = {8'd192, 8'd168};
                3: a[31:16] = {8'd198, 8'($urandom_range(16, 21))};
                4: a[31:16] = {8'd100, 8'($urandom_range(60, 130))};
                5: a[31:8] = {8'd192, 8'd0, 8'd2};
                6: a[31:8] = {8'd198, 8'd51, 8'd100};
                7: a[31:8] = {8'd203, 8'd0, 8'd113};
                8: a[31:16] = {8'd169, 8'($urandom_range(253, 255))};
                9: a[31:24] = 8'd127;
                10: a[31:28] = 4'hE;
                11: a = '0;
                12: a = 32'($urandom_range(0, 3));
                default: ;
            endcase
            w.addr_lo[31:0] = a;
        end
        return w;
    endfunction

    task automatic send_word(ipac_item_t w);
        start <= 1'b1;
        item <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.class_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(int unsigned count, int unsigned idle_pct);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_word(random_address());
            if ($urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                item <= random_address();
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(1'b0, '1, 64'hFFFFFFFF_00000000, 16'd0));
        send_word(make_word(1'b0, '0, 64'hFFFFFFFF, 16'hFFFF));
        send_word(make_word(1'b0, '0, 64'h0A000001, 16'd1));
        send_word(make_word(1'b0, '0, 64'hAC100001, 16'd2));
        send_word(make_word(1'b0, '0, 64'hAC1FFFFF, 16'hFFFE));
        send_word(make_word(1'b0, '0, 64'hC0A80001, 16'd80));
        send_word(make_word(1'b0, '0, 64'hC6120001, 16'd443));
        send_word(make_word(1'b0, '0, 64'h64400001, 16'd53));
        send_word(make_word(1'b0, '0, 64'hC0000201, 16'd1000));
        send_word(make_word(1'b0, '0, 64'hC6336401, 16'd1000));
        send_word(make_word(1'b0, '0, 64'hCB007101, 16'd1000));
        send_word(make_word(1'b0, '0, 64'hA9FE0001, 16'd1000));
        send_word(make_word(1'b0, '0, 64'h7F000001, 16'd1000));
        send_word(make_word(1'b0, '0, 64'hE0000001, 16'd1000));
        send_word(make_word(1'b1, '0, '0, 16'd0));
        send_word(make_word(1'b1, '0, 64'd1, 16'd2));
        send_word(make_word(1'b1, 64'hFF02000000000000, 64'd1, 16'd1000));
        send_word(make_word(1'b1, 64'h20010DB800000000, 64'd1, 16'd1000));
        send_word(make_word(1'b1, 64'h2002000000000000, 64'd1, 16'd1000));
        send_word(make_word(1'b1, 64'hFD00000000000000, 64'd1, 16'd1000));
        send_word(make_word(1'b1, 64'h2001000000000000, 64'd1, 16'd1000));
        send_word(make_word(1'b1, 64'h2001001F00000000, 64'd1, 16'd1000));
        send_word(make_word(1'b1, 64'hFE80000000000000, 64'd1, 16'd1000));
        send_word(make_word(1'b1, 64'h0064FF9B00000000, 64'h01020304, 16'd1000));
        send_word(make_word(1'b1, '0, 64'hFFFF0000_01020304, 16'd1000));
        send_word(make_word(1'b1, '1, '1, 16'hFFFF));
        drain_results();

        send_random(PHASE_WORDS, 36);
        drain_results();
        send_random(PHASE_WORDS, 77);
        drain_results();
        send_random(PHASE_WORDS, 0);
        drain_results();

        if (sb.fails == 0 && sb.class_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ipac_pkg.sv
src/ip_address_classifier.sv
sim/tb_ip_address_classifier.sv
